// ===== hw/rtl/abpp_pkg.sv =====
`default_nettype none

package abpp_pkg;

    // Fixed format limits
    localparam int DIM_DIGITS    = 5;   // max digits in width or height
    localparam int MAX_CODE_BITS = 16;  // widest point number that decodes
    localparam int DIM_W         = 17;  // width/height/coordinate bits
    localparam int NUMBER_W      = 32;
    localparam int NBITS_W       = 6;
    localparam int TDATA_W       = 112;

    // Configuration register indexes
    localparam logic CFG_NUM_BITS  = 1'b0;
    localparam logic CFG_INIT_MODE = 1'b1;

    // Result kinds (m_tuser)
    localparam logic [1:0] EV_SIZE  = 2'd0;
    localparam logic [1:0] EV_POINT = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;
    localparam logic [1:0] EV_END   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_HASH_IN_MAGIC = 3'd0;
    localparam logic [2:0] ERR_MAGIC_LONG    = 3'd1;
    localparam logic [2:0] ERR_NOT_P1        = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR      = 3'd3;
    localparam logic [2:0] ERR_TOO_WIDE      = 3'd4;
    localparam logic [2:0] ERR_TOO_HIGH      = 3'd5;
    localparam logic [2:0] ERR_UNEXP_END     = 3'd6;

    typedef struct packed {
        logic [NBITS_W-1:0] num_bits;
        logic               init_mode;
    } cfg_t;

    // Classified request, as queued between front and back
    typedef struct packed {
        logic       eof;
        logic [7:0] byte_v;
        logic       is_hash;
        logic       is_space;
        logic       is_eol;
        logic       is_bit;
        logic       is_zero;
        logic       is_magic;
        logic       is_digit;
        logic       is_nzdigit;
        logic [3:0] digit;
    } entry_t;

    // Result payload; first member is the MSB, so img_width lands at bit 0
    typedef struct packed {
        logic                success;
        logic [2:0]          error_code;
        logic [NUMBER_W-1:0] point_number;
        logic                point_active;
        logic [DIM_W-1:0]    point_y;
        logic [DIM_W-1:0]    point_x;
        logic [DIM_W-1:0]    img_height;
        logic [DIM_W-1:0]    img_width;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== hw/rtl/abpp_front.sv =====
`default_nettype none

module abpp_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tuser,
    output logic                 q_valid,
    output abpp_pkg::entry_t     q_entry,
    input  wire logic            q_pop
);
    import abpp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    entry_t             cls;
    logic               push;

    // byte classification
    always_comb
    begin
        cls            = '0;
        cls.eof        = s_tuser;
        cls.byte_v     = s_tdata;
        cls.is_hash    = (s_tdata == 8'h23);
        cls.is_space   = (s_tdata == 8'h20) || (s_tdata >= 8'h09 && s_tdata <= 8'h0D);
        cls.is_eol     = (s_tdata == 8'h0A) || (s_tdata == 8'h0D);
        cls.is_bit     = (s_tdata == 8'h30) || (s_tdata == 8'h31);
        cls.is_zero    = (s_tdata == 8'h30);
        cls.is_magic   = (s_tdata == 8'h50) || (s_tdata >= 8'h31 && s_tdata <= 8'h37);
        cls.is_digit   = (s_tdata >= 8'h30 && s_tdata <= 8'h39);
        cls.is_nzdigit = (s_tdata >= 8'h31 && s_tdata <= 8'h39);
        cls.digit      = s_tdata[3:0];
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/abpp_back.sv =====
`default_nettype none

module abpp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire abpp_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    input  wire abpp_pkg::entry_t   q_entry,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              out_kind,
    output abpp_pkg::result_t       out_res
);
    import abpp_pkg::*;

    localparam logic [3:0] ST_CORRUPTED = 4'd0;
    localparam logic [3:0] ST_MAGIC     = 4'd1;
    localparam logic [3:0] ST_FIND_W    = 4'd2;
    localparam logic [3:0] ST_READ_W    = 4'd3;
    localparam logic [3:0] ST_FIND_H    = 4'd4;
    localparam logic [3:0] ST_READ_H    = 4'd5;
    localparam logic [3:0] ST_PIXELS    = 4'd6;
    localparam logic [3:0] ST_FLAG      = 4'd7;
    localparam logic [3:0] ST_NUMBER    = 4'd8;
    localparam logic [3:0] ST_COMMENT   = 4'd9;
    localparam logic [3:0] ST_FINISHED  = 4'd10;

    logic [3:0]               state_reg, state_next;
    logic [3:0]               ret_reg, ret_next;
    logic [15:0]              magic_reg, magic_next;
    logic [DIM_W-1:0]         dval_reg, dval_next;
    logic [NBITS_W-1:0]       dcnt_reg, dcnt_next;
    logic [MAX_CODE_BITS-1:0] code_reg, code_next;
    logic [DIM_W-1:0]         img_w_reg, img_w_next;
    logic [DIM_W-1:0]         img_h_reg, img_h_next;
    logic [DIM_W-1:0]         row_reg, row_next;
    logic [DIM_W-1:0]         col_reg, col_next;
    logic [DIM_W-1:0]         hx_reg, hx_next;
    logic [DIM_W-1:0]         hy_reg, hy_next;
    logic                     hact_reg, hact_next;
    logic [NUMBER_W-1:0]      serial_reg, serial_next;

    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg;
    result_t                  out_res_reg;

    logic                     produce;
    logic [1:0]               kind;
    result_t                  res;

    logic [DIM_W-1:0]         col_inc, row_inc, col_adv, row_adv, dval_x10;
    logic                     wrap, adv_done;
    logic [NBITS_W-1:0]       dcnt_inc;
    logic [MAX_CODE_BITS-1:0] code_new;
    logic                     slot_free;

    // pixel walk step
    assign col_inc  = col_reg + 1'b1;
    assign row_inc  = row_reg + 1'b1;
    assign wrap     = (col_inc == img_w_reg);
    assign adv_done = wrap && (row_inc == img_h_reg);
    assign col_adv  = wrap ? '0 : col_inc;
    assign row_adv  = wrap ? row_inc : row_reg;

    assign dcnt_inc = dcnt_reg + 1'b1;
    assign dval_x10 = (dval_reg << 3) + (dval_reg << 1);
    assign code_new = {code_reg[MAX_CODE_BITS-2:0], q_entry.is_zero};

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        magic_next  = magic_reg;
        dval_next   = dval_reg;
        dcnt_next   = dcnt_reg;
        code_next   = code_reg;
        img_w_next  = img_w_reg;
        img_h_next  = img_h_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        hx_next     = hx_reg;
        hy_next     = hy_reg;
        hact_next   = hact_reg;
        serial_next = serial_reg;
        produce     = 1'b0;
        kind        = EV_SIZE;
        res         = '0;

        if (q_valid)
        begin
            if (q_entry.eof)
            begin
                produce     = 1'b1;
                kind        = EV_END;
                res.success = (state_reg == ST_FINISHED);
                state_next  = ST_MAGIC;
                ret_next    = ST_CORRUPTED;
                magic_next  = '0;
                dval_next   = '0;
                dcnt_next   = '0;
                code_next   = '0;
                img_w_next  = '0;
                img_h_next  = '0;
                row_next    = '0;
                col_next    = '0;
                hx_next     = '0;
                hy_next     = '0;
                hact_next   = 1'b1;
                serial_next = '0;
            end
            else if (state_reg == ST_CORRUPTED || state_reg >= ST_FINISHED)
            begin
                // parser is parked until end of file
            end
            else if (q_entry.is_hash)
            begin
                if (state_reg == ST_MAGIC)
                begin
                    produce        = 1'b1;
                    kind           = EV_ERROR;
                    res.error_code = ERR_HASH_IN_MAGIC;
                    state_next     = ST_CORRUPTED;
                end
                else if (state_reg != ST_COMMENT)
                begin
                    ret_next   = state_reg;
                    state_next = ST_COMMENT;
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_MAGIC:
                    begin
                        if (q_entry.is_magic)
                        begin
                            magic_next = {magic_reg[7:0], q_entry.byte_v};
                            dcnt_next  = dcnt_inc;
                            if (dcnt_inc > NBITS_W'(2))
                            begin
                                produce        = 1'b1;
                                kind           = EV_ERROR;
                                res.error_code = ERR_MAGIC_LONG;
                                state_next     = ST_CORRUPTED;
                            end
                        end
                        else if (q_entry.is_space)
                        begin
                            if (dcnt_reg == NBITS_W'(2) && magic_reg == 16'h5031)
                            begin
                                magic_next = '0;
                                dcnt_next  = '0;
                                state_next = ST_FIND_W;
                            end
                            else
                            begin
                                produce        = 1'b1;
                                kind           = EV_ERROR;
                                res.error_code = ERR_NOT_P1;
                                state_next     = ST_CORRUPTED;
                            end
                        end
                        else
                        begin
                            produce        = 1'b1;
                            kind           = EV_ERROR;
                            res.error_code = ERR_BAD_CHAR;
                            state_next     = ST_CORRUPTED;
                        end
                    end
                    ST_FIND_W, ST_FIND_H:
                    begin
                        if (q_entry.is_nzdigit)
                        begin
                            dval_next  = DIM_W'(q_entry.digit);
                            dcnt_next  = NBITS_W'(1);
                            state_next = state_reg + 1'b1;
                        end
                        else if (!q_entry.is_space)
                        begin
                            produce        = 1'b1;
                            kind           = EV_ERROR;
                            res.error_code = ERR_BAD_CHAR;
                            state_next     = ST_CORRUPTED;
                        end
                    end
                    ST_READ_W, ST_READ_H:
                    begin
                        if (q_entry.is_digit)
                        begin
                            dcnt_next = dcnt_inc;
                            if (dcnt_inc > NBITS_W'(DIM_DIGITS))
                            begin
                                produce        = 1'b1;
                                kind           = EV_ERROR;
                                res.error_code = (state_reg == ST_READ_W) ? ERR_TOO_WIDE
                                                                          : ERR_TOO_HIGH;
                                state_next     = ST_CORRUPTED;
                            end
                            else
                            begin
                                dval_next = dval_x10 + DIM_W'(q_entry.digit);
                            end
                        end
                        else if (q_entry.is_space)
                        begin
                            dcnt_next = '0;
                            if (state_reg == ST_READ_W)
                            begin
                                img_w_next = dval_reg;
                                state_next = ST_FIND_H;
                            end
                            else
                            begin
                                img_h_next     = dval_reg;
                                state_next     = ST_PIXELS;
                                produce        = 1'b1;
                                kind           = EV_SIZE;
                                res.img_width  = img_w_reg;
                                res.img_height = dval_reg;
                            end
                        end
                        else
                        begin
                            produce        = 1'b1;
                            kind           = EV_ERROR;
                            res.error_code = ERR_BAD_CHAR;
                            state_next     = ST_CORRUPTED;
                        end
                    end
                    ST_PIXELS:
                    begin
                        if (q_entry.is_bit)
                        begin
                            if (q_entry.is_zero)
                            begin
                                hx_next    = col_reg;
                                hy_next    = row_reg;
                                state_next = ST_FLAG;
                            end
                            col_next = col_adv;
                            row_next = row_adv;
                            if (adv_done)
                            begin
                                state_next = ST_FINISHED;
                            end
                        end
                        else if (!q_entry.is_space)
                        begin
                            produce        = 1'b1;
                            kind           = EV_ERROR;
                            res.error_code = ERR_BAD_CHAR;
                            state_next     = ST_CORRUPTED;
                        end
                    end
                    ST_FLAG:
                    begin
                        if (q_entry.is_bit)
                        begin
                            hact_next  = cfg.init_mode | q_entry.is_zero;
                            state_next = ST_NUMBER;
                            dcnt_next  = '0;
                            code_next  = '0;
                            col_next   = col_adv;
                            row_next   = row_adv;
                            if (adv_done)
                            begin
                                produce        = 1'b1;
                                kind           = EV_ERROR;
                                res.error_code = ERR_UNEXP_END;
                                state_next     = ST_CORRUPTED;
                            end
                        end
                        else if (!q_entry.is_space)
                        begin
                            produce        = 1'b1;
                            kind           = EV_ERROR;
                            res.error_code = ERR_BAD_CHAR;
                            state_next     = ST_CORRUPTED;
                        end
                    end
                    ST_NUMBER:
                    begin
                        if (q_entry.is_bit)
                        begin
                            code_next = code_new;
                            dcnt_next = dcnt_inc;
                            col_next  = col_adv;
                            row_next  = row_adv;
                            if (dcnt_inc == cfg.num_bits)
                            begin
                                produce          = 1'b1;
                                kind             = EV_POINT;
                                res.point_x      = hx_reg;
                                res.point_y      = hy_reg;
                                res.point_active = hact_reg;
                                if (cfg.init_mode)
                                begin
                                    serial_next      = serial_reg + 1'b1;
                                    res.point_number = serial_reg + 1'b1;
                                end
                                else if (cfg.num_bits == '0 ||
                                         cfg.num_bits > NBITS_W'(MAX_CODE_BITS))
                                begin
                                    res.point_number = '0;
                                end
                                else
                                begin
                                    res.point_number = NUMBER_W'(code_new);
                                end
                                dcnt_next  = '0;
                                code_next  = '0;
                                state_next = adv_done ? ST_FINISHED : ST_PIXELS;
                            end
                            else if (adv_done)
                            begin
                                produce        = 1'b1;
                                kind           = EV_ERROR;
                                res.error_code = ERR_UNEXP_END;
                                state_next     = ST_CORRUPTED;
                            end
                        end
                        else if (!q_entry.is_space)
                        begin
                            produce        = 1'b1;
                            kind           = EV_ERROR;
                            res.error_code = ERR_BAD_CHAR;
                            state_next     = ST_CORRUPTED;
                        end
                    end
                    ST_COMMENT:
                    begin
                        if (q_entry.is_eol)
                        begin
                            state_next = ret_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // a request that yields nothing retires even while the output slot is full
    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = q_valid && (!produce || slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_MAGIC;
            ret_reg       <= ST_CORRUPTED;
            magic_reg     <= '0;
            dval_reg      <= '0;
            dcnt_reg      <= '0;
            code_reg      <= '0;
            img_w_reg     <= '0;
            img_h_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            hx_reg        <= '0;
            hy_reg        <= '0;
            hact_reg      <= 1'b1;
            serial_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                state_reg  <= state_next;
                ret_reg    <= ret_next;
                magic_reg  <= magic_next;
                dval_reg   <= dval_next;
                dcnt_reg   <= dcnt_next;
                code_reg   <= code_next;
                img_w_reg  <= img_w_next;
                img_h_reg  <= img_h_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
                hx_reg     <= hx_next;
                hy_reg     <= hy_next;
                hact_reg   <= hact_next;
                serial_reg <= serial_next;
            end
            if (q_pop && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && produce)
        begin
            out_kind_reg <= kind;
            out_res_reg  <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_bitmap_point_parser_unit.sv =====
// Plain-bitmap (P1) point parser, one file byte per request.
// An accepted request is written into the queue, then the parse step puts any result it yields
//   into the output register, which drives m_tvalid.
// Throughput: one request per cycle while the output register is free or being read;
//   requests that yield no result retire even while the output register is held.
// Reset: rst_n asynchronous, active low; parser back to magic search, queue and output
//   emptied, num_bits = 10, init_mode = 0.
`default_nettype none

module ascii_bitmap_point_parser_unit #(
    parameter int QUEUE_DEPTH = 4   // classified requests buffered, 2 or more
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    // request stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] byte_req
    input  wire logic                         s_tuser,   // [0] op (1 = end of file)

    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [16:0] img_width, [33:17] img_height, [50:34] point_x, [67:51] point_y,
    // [68] point_active, [100:69] point_number, [103:101] error_code,
    // [104] success, [111:105] zero
    output logic [abpp_pkg::TDATA_W-1:0]      m_tdata,
    output logic [1:0]                        m_tuser,   // [1:0] event_kind

    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index, // 0 num_bits, 1 init_mode
    input  wire logic [abpp_pkg::NBITS_W-1:0] cfg_wdata
);
    import abpp_pkg::*;

    cfg_t       cfg_reg;
    logic       q_valid;
    entry_t     q_entry;
    logic       q_pop;
    result_t    out_res;

    // Config registers; the user must write them only while the block is idle, not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_bits  <= NBITS_W'(10);
            cfg_reg.init_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_BITS:  cfg_reg.num_bits  <= cfg_wdata;
                CFG_INIT_MODE: cfg_reg.init_mode <= cfg_wdata[0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Front end: classify each byte, queue it.
    abpp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // Back end: parse state machine plus output register.
    abpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_res   (out_res)
    );

    assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, out_res};

endmodule

`default_nettype wire

// ===== hw/rtl/abpp_checker.sv =====
`default_nettype none

module abpp_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [abpp_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic [1:0]                   m_tuser
);
    import abpp_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata[RES_W-1:0]);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_ERROR |-> res.error_code <= ERR_UNEXP_END)
        else $error("error code out of range");

    a_size_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_SIZE |-> res.img_width == '0 && res.img_height == '0)
        else $error("size fields set on non-size event");

    a_success_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_END |-> !res.success)
        else $error("success flag outside end event");

endmodule

bind ascii_bitmap_point_parser_unit abpp_checker u_abpp_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import abpp_pkg::*;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 6;
    localparam int TIMEOUT_CYCLES   = 400_000;
    localparam int PHASES           = 10;
    localparam int RANDOM_PER_PHASE = 100;   // requests per configuration phase
    localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off for the back-pressure test
    localparam int SETTLE_CYCLES    = 16;    // covers queue depth plus the output register
    localparam int DRAIN_LIMIT      = 20_000;

    // Request kinds on s_tuser
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // Characters the parser reacts to
    localparam logic [7:0]  CH_HASH  = "#";
    localparam logic [7:0]  CH_ZERO  = "0";
    localparam logic [7:0]  CH_ONE   = "1";
    localparam logic [7:0]  CH_SEVEN = "7";
    localparam logic [7:0]  CH_NINE  = "9";
    localparam logic [7:0]  CH_P     = "P";
    localparam logic [7:0]  CH_LF    = 8'd10;
    localparam logic [7:0]  CH_CR    = 8'd13;
    localparam logic [7:0]  CH_TAB   = 8'd9;
    localparam logic [7:0]  CH_SPACE = 8'd32;
    localparam logic [15:0] MAGIC_P1 = "P1";

    typedef enum logic [3:0] {
        PH_CORRUPTED,
        PH_MAGIC,
        PH_FIND_W,
        PH_READ_W,
        PH_FIND_H,
        PH_READ_H,
        PH_PIXELS,
        PH_FLAG,
        PH_NUMBER,
        PH_COMMENT,
        PH_FINISHED
    } parse_phase_e;

    typedef struct packed {
        logic [1:0] kind;
        result_t    res;
    } bitmap_event_t;

    // Tracks the parser state for every accepted request and holds the events it
    // should emit, oldest first.
    class bitmap_scoreboard;
        logic [NBITS_W-1:0]       num_bits;
        logic                     init_mode;
        parse_phase_e             phase;
        parse_phase_e             resume_phase;
        logic [15:0]              magic;
        logic [5:0]               digit_cnt;   // 6 bits: wraps when num_bits is 0
        logic [DIM_W-1:0]         dim_value;
        logic [MAX_CODE_BITS-1:0] code;
        int unsigned              width;
        int unsigned              height;
        int unsigned              row;
        int unsigned              col;
        logic [DIM_W-1:0]         mark_x;
        logic [DIM_W-1:0]         mark_y;
        logic                     mark_active;
        logic [NUMBER_W-1:0]      serial;
        bitmap_event_t            expected_events[$];
        int unsigned              failures;

        function new();
            num_bits  = NBITS_W'(10);
            init_mode = 1'b0;
            failures  = 0;
            rearm();
        endfunction

        function void rearm();
            phase        = PH_MAGIC;
            resume_phase = PH_CORRUPTED;
            magic        = '0;
            digit_cnt    = '0;
            dim_value    = '0;
            code         = '0;
            width        = 0;
            height       = 0;
            row          = 0;
            col          = 0;
            mark_x       = '0;
            mark_y       = '0;
            mark_active  = 1'b1;
            serial       = '0;
        endfunction

        function void write_reg(logic idx, logic [NBITS_W-1:0] value);
            if (idx == CFG_NUM_BITS)
                num_bits = value;
            else
                init_mode = value[0];
        endfunction

        // Step to the next pixel; true once the last pixel has been passed.
        function bit next_pixel();
            col++;
            if (col == width)
            begin
                col = 0;
                row++;
                if (row == height)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void post(logic [1:0] kind, result_t res);
            bitmap_event_t ev;
            ev.kind = kind;
            ev.res  = res;
            expected_events.push_back(ev);
        endfunction

        function void corrupt(logic [2:0] err);
            result_t res;
            res = '0;
            res.error_code = err;
            post(EV_ERROR, res);
            phase = PH_CORRUPTED;
        endfunction

        function void note_request(logic op, logic [7:0] c);
            result_t             res;
            bit                  pix;
            bit                  blank;
            int unsigned         len;
            logic [NUMBER_W-1:0] number;
            res   = '0;
            pix   = (c == CH_ZERO || c == CH_ONE);
            blank = (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));

            if (op == OP_EOF)
            begin
                res.success = (phase == PH_FINISHED);
                post(EV_END, res);
                rearm();
                return;
            end
            if (phase == PH_CORRUPTED || phase == PH_FINISHED)
                return;

            if (c == CH_HASH)
            begin
                if (phase == PH_MAGIC)
                    corrupt(ERR_HASH_IN_MAGIC);
                else if (phase != PH_COMMENT)
                begin
                    resume_phase = phase;
                    phase        = PH_COMMENT;
                end
                return;
            end

            case (phase)
                PH_MAGIC:
                    if (c == CH_P || (c >= CH_ONE && c <= CH_SEVEN))
                    begin
                        magic = {magic[7:0], c};
                        digit_cnt++;
                        if (digit_cnt > 2)
                            corrupt(ERR_MAGIC_LONG);
                    end
                    else if (blank)
                    begin
                        if (digit_cnt == 2 && magic == MAGIC_P1)
                        begin
                            magic     = '0;
                            digit_cnt = '0;
                            phase     = PH_FIND_W;
                        end
                        else
                            corrupt(ERR_NOT_P1);
                    end
                    else
                        corrupt(ERR_BAD_CHAR);
                PH_FIND_W, PH_FIND_H:
                    if (c >= CH_ONE && c <= CH_NINE)
                    begin
                        dim_value = DIM_W'(c - CH_ZERO);
                        digit_cnt = 6'd1;
                        phase     = (phase == PH_FIND_W) ? PH_READ_W : PH_READ_H;
                    end
                    else if (!blank)
                        corrupt(ERR_BAD_CHAR);
                PH_READ_W, PH_READ_H:
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        digit_cnt++;
                        if (digit_cnt > DIM_DIGITS)
                            corrupt(phase == PH_READ_W ? ERR_TOO_WIDE : ERR_TOO_HIGH);
                        else
                            dim_value = DIM_W'(dim_value * 10 + (c - CH_ZERO));
                    end
                    else if (blank)
                    begin
                        digit_cnt = '0;
                        if (phase == PH_READ_W)
                        begin
                            width = 32'(dim_value);
                            phase = PH_FIND_H;
                        end
                        else
                        begin
                            height         = 32'(dim_value);
                            phase          = PH_PIXELS;
                            res.img_width  = DIM_W'(width);
                            res.img_height = DIM_W'(height);
                            post(EV_SIZE, res);
                        end
                    end
                    else
                        corrupt(ERR_BAD_CHAR);
                PH_PIXELS:
                    if (pix)
                    begin
                        if (c == CH_ZERO)
                        begin
                            mark_x = DIM_W'(col);
                            mark_y = DIM_W'(row);
                            phase  = PH_FLAG;
                        end
                        // a marker on the very last pixel just ends the image
                        if (next_pixel())
                            phase = PH_FINISHED;
                    end
                    else if (!blank)
                        corrupt(ERR_BAD_CHAR);
                PH_FLAG:
                    if (pix)
                    begin
                        mark_active = init_mode ? 1'b1 : (c == CH_ZERO);
                        phase       = PH_NUMBER;
                        digit_cnt   = '0;
                        code        = '0;
                        if (next_pixel())
                            corrupt(ERR_UNEXP_END);
                    end
                    else if (!blank)
                        corrupt(ERR_BAD_CHAR);
                PH_NUMBER:
                    if (pix)
                    begin
                        code = {code[MAX_CODE_BITS-2:0], c == CH_ZERO};
                        digit_cnt++;
                        if (digit_cnt == num_bits)
                        begin
                            len = (digit_cnt == 0) ? 64 : 32'(digit_cnt);
                            if (init_mode)
                            begin
                                serial++;
                                number = serial;
                            end
                            else
                                number = (len > MAX_CODE_BITS) ? '0 : NUMBER_W'(code);
                            res.point_x      = mark_x;
                            res.point_y      = mark_y;
                            res.point_active = mark_active;
                            res.point_number = number;
                            post(EV_POINT, res);
                            digit_cnt = '0;
                            code      = '0;
                            phase     = PH_PIXELS;
                        end
                        if (next_pixel())
                        begin
                            if (phase == PH_NUMBER)
                                corrupt(ERR_UNEXP_END);
                            else
                                phase = PH_FINISHED;
                        end
                    end
                    else if (!blank)
                        corrupt(ERR_BAD_CHAR);
                PH_COMMENT:
                    if (c == CH_LF || c == CH_CR)
                        phase = resume_phase;
                default:
                    ;
            endcase
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [TDATA_W-1:0] data);
            bitmap_event_t want;
            result_t       got;
            got = result_t'(data[RES_W-1:0]);
            if (expected_events.size() == 0)
            begin
                $error("event_kind: expected none, got %0d", kind);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            check_field("event_kind", want.kind, kind);
            check_field("img_width", want.res.img_width, got.img_width);
            check_field("img_height", want.res.img_height, got.img_height);
            check_field("point_x", want.res.point_x, got.point_x);
            check_field("point_y", want.res.point_y, got.point_y);
            check_field("point_active", want.res.point_active, got.point_active);
            check_field("point_number", want.res.point_number, got.point_number);
            check_field("error_code", want.res.error_code, got.error_code);
            check_field("success", want.res.success, got.success);
            check_field("tdata padding", '0, data[TDATA_W-1:RES_W]);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                cfg_we;
    logic                cfg_index;
    logic [NBITS_W-1:0]  cfg_wdata;

    bitmap_scoreboard    sb;
    logic [7:0]          file_bytes[$];    // one file's bytes, EOF request not included
    int unsigned         requests_sent = 0;
    bit                  sender_gaps   = 1'b0;
    bit                  quiet_tail    = 1'b0;   // no idling on either side
    bit                  long_hold     = 1'b0;   // asks the receiver for one long hold-off

    ascii_bitmap_point_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // File builders: they fill file_bytes, send_file streams it.
    // ---------------------------------------------------------------
    function automatic void add_text(string s);
        foreach (s[i])
            file_bytes.push_back(s[i]);
    endfunction

    function automatic void add_number(int unsigned v);
        add_text($sformatf("%0d", v));
    endfunction

    function automatic logic [7:0] blank_char();
        int unsigned r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : r[7:0];
    endfunction

    // White space, sometimes followed by a comment that runs to end of line.
    // Comment bodies carry arbitrary bytes, '#' included.
    function automatic void add_blank();
        logic [7:0] b;
        repeat ($urandom_range(1, 3))
            file_bytes.push_back(blank_char());
        if ($urandom_range(0, 5) == 0)
        begin
            file_bytes.push_back(CH_HASH);
            repeat ($urandom_range(0, 6))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_LF || b == CH_CR)
                    b = CH_HASH;
                file_bytes.push_back(b);
            end
            file_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
            file_bytes.push_back(blank_char());
        end
    endfunction

    function automatic void add_header(int unsigned w, int unsigned h);
        add_text("P1");
        add_blank();
        add_number(w);
        add_blank();
        add_number(h);
        add_blank();
    endfunction

    function automatic void add_pixels(int unsigned count, int unsigned zero_pct);
        repeat (count)
        begin
            file_bytes.push_back(($urandom_range(0, 99) < zero_pct) ? CH_ZERO : CH_ONE);
            if ($urandom_range(0, 9) == 0)
                add_blank();
        end
    endfunction

    // Broken headers: each trips a header error, unless the random byte after P1 is white space.
    function automatic void add_bad_header();
        case ($urandom_range(0, 7))
            0:
            begin
                add_text("P2");
                add_blank();
            end
            1:
            begin
                add_text("P");
                add_blank();
            end
            2:
            begin
                add_text("P1");
                add_blank();
                add_text("0");
            end
            3:
            begin
                add_text("P1");
                add_blank();
                add_number($urandom_range(100000, 999999));
            end
            4:
            begin
                add_text("P1");
                add_blank();
                add_number($urandom_range(1, 99));
                add_blank();
                add_number($urandom_range(100000, 999999));
            end
            5:
            begin
                add_text("P1");
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            6: add_text("P1 12 3x");
            default: add_text("P11");
        endcase
    endfunction

    function automatic void build_random_file();
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int unsigned keep;
        file_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            // well-formed small image, now and then damaged or cut short
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            add_header(w, h);
            add_pixels(w * h, $urandom_range(5, 70));
            case ($urandom_range(0, 9))
                0:
                begin
                    keep = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[keep] = 8'($urandom_range(0, 255));
                end
                1:
                begin
                    keep = $urandom_range(0, file_bytes.size() - 1);
                    while (file_bytes.size() > keep)
                        void'(file_bytes.pop_back());
                end
                default: ;
            endcase
        end
        else if (r < 75)
        begin
            add_bad_header();
            add_pixels($urandom_range(0, 4), 50);
        end
        else if (r < 82)
        begin
            // huge dimensions, only a few pixels before end of file
            add_header($urandom_range(1, 99999), $urandom_range(1, 99999));
            add_pixels($urandom_range(0, 40), 40);
        end
        else if (r < 92)
        begin
            repeat ($urandom_range(0, 8))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // long rows, enough room for wide point numbers
            w = $urandom_range(20, 60);
            h = $urandom_range(1, 3);
            add_header(w, h);
            add_pixels(w * h, 60);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request side. Drive on the falling edge, sample on the rising edge.
    // tvalid stays high between back-to-back requests.
    // ---------------------------------------------------------------
    task automatic push_request(logic op, logic [7:0] b);
        int unsigned gap;
        if (sender_gaps && !quiet_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, b);
        requests_sent++;
    endtask

    // Whole file followed by end of file; the EOF byte is don't-care, so random.
    task automatic send_file();
        sender_gaps = ($urandom_range(0, 1) == 1);
        foreach (file_bytes[i])
            push_request(OP_DATA, file_bytes[i]);
        push_request(OP_EOF, 8'($urandom_range(0, 255)));
    endtask

    // Stop offering, wait for every expected event, then let requests that
    // produce nothing work their way out of the queue.
    task automatic drain();
        int unsigned guard;
        guard = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_events.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic idx, logic [NBITS_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // ---------------------------------------------------------------
    // Result side: random ready bursts, one long hold-off on request,
    // always ready in the tail of the run.
    // ---------------------------------------------------------------
    initial
    begin : receiver
        int unsigned burst_left;
        bit          stalling;
        burst_left = 0;
        stalling   = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold  = 1'b0;
                burst_left = 0;
                m_tready  <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else if (quiet_tail)
                m_tready <= 1'b1;
            else
            begin
                if (burst_left == 0)
                begin
                    stalling   = ($urandom_range(0, 2) == 0);
                    burst_left = $urandom_range(1, 16);
                end
                m_tready <= !stalling;
                burst_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        // num_bits / init_mode per phase: extremes of the 6-bit field, the
        // decode limit and one past it, both modes
        int unsigned phase_bits[PHASES];
        bit          phase_init[PHASES];
        int unsigned goal;

        phase_bits = '{1, 32, 16, 17, 0, 63, 2, 32, 4, 10};
        phase_init = '{0, 1, 0, 0, 0, 1, 1, 0, 0, 1};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_DATA;
        cfg_we    = 1'b0;
        cfg_index = CFG_NUM_BITS;
        cfg_wdata = '0;
        sb        = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed files, reset configuration.
        // '#' before the magic
        file_bytes.delete();
        add_text("#");
        send_file();
        // third magic character, '7' accepted as a magic char
        file_bytes.delete();
        add_text("P71");
        send_file();
        // empty magic
        file_bytes.delete();
        add_text(" ");
        send_file();
        // top byte value is a bad char; the zero byte after it is ignored
        file_bytes.delete();
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        send_file();
        // comment with '#' inside ended by CR; 1x1 image whose only pixel is a
        // marker, so it finishes cleanly with no point
        file_bytes.delete();
        add_text("P1\n##\r1 1 0");
        send_file();
        // leading zero in width
        file_bytes.delete();
        add_text("P1 0");
        send_file();

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            set_register(CFG_NUM_BITS, NBITS_W'(phase_bits[p]));
            set_register(CFG_INIT_MODE, NBITS_W'(phase_init[p]));
            if (p == 0)
            begin
                // all-marker image: a point every three pixels, the last one
                // ends on the final pixel; receiver holds off meanwhile so the
                // block backs up and drops s_tready
                file_bytes.delete();
                add_header(12, 8);
                repeat (96) file_bytes.push_back(CH_ZERO);
                long_hold = 1'b1;
                send_file();
            end
            goal = requests_sent + RANDOM_PER_PHASE;
            while (requests_sent < goal)
            begin
                build_random_file();
                send_file();
            end
        end

        drain();
        if (sb.expected_events.size() != 0)
        begin
            $error("%0d expected events never arrived", sb.expected_events.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/abpp_pkg.sv
hw/rtl/abpp_front.sv
hw/rtl/abpp_back.sv
hw/rtl/ascii_bitmap_point_parser_unit.sv
hw/rtl/abpp_checker.sv
verif/testbench.sv
